FILE: design/can_txq_pkg.sv
package can_txq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PtrW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW        = $clog2(QUEUE_DEPTH);

  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned FillW    = 4;
  localparam int unsigned DropW    = 16;

  typedef enum logic {
    OP_SUBMIT   = 1'b0,
    OP_COMPLETE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    OUT_DIRECT   = 2'd0,
    OUT_QUEUED   = 2'd1,
    OUT_DROPPED  = 2'd2,
    OUT_COMPLETE = 2'd3
  } outcome_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // one ring entry: header fields plus payload
  typedef struct packed {
    logic [IdW-1:0]      id;
    logic                extended;
    logic [LenW-1:0]     length;
    logic [PayloadW-1:0] payload;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // fill level seen on the port saturates at 15
  function automatic logic [FillW-1:0] fill_sat(input logic [CntW-1:0] cnt);
    logic [8:0] c9;
    c9 = 9'(cnt);
    fill_sat = (c9 > 9'd15) ? 4'd15 : c9[3:0];
  endfunction

endpackage

FILE: design/can_txq_ram.sv
module can_txq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/can_tx_queue_with_bypass_core.sv
// A submit, or a completion with nothing queued, shows its item in the cycle after accept.
// A completion that pops the ring shows its item after the ring RAM read (ST_READ), then the output register.
// One item per cycle while the output register is free or being drained, except a popping
// completion, which holds the input while the ring RAM read is in flight.
// Reset (rst_ni low, async): pointers, count, mailbox flag, drop counter and output valid clear;
// ring RAM contents are not cleared, entries are only read after being written.
module can_tx_queue_with_bypass_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [28:0] msg_id_i,
  input  logic        msg_extended_i,
  input  logic [3:0]  msg_length_i,
  input  logic [63:0] msg_payload_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        load_mailbox_o,
  output logic [28:0] out_id_o,
  output logic        out_extended_o,
  output logic [3:0]  out_length_o,
  output logic [63:0] out_payload_o,
  output logic [1:0]  outcome_o,
  output logic [3:0]  fill_level_o,
  output logic [15:0] drop_total_o
);

  localparam int unsigned PtrW = can_txq_pkg::PtrW;
  localparam int unsigned CntW = can_txq_pkg::CntW;

  // ---------------------------------------------------------------------------
  // Queue control state
  // ---------------------------------------------------------------------------
  can_txq_pkg::state_e state_q, state_d;
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;       // mailbox holds a message in flight
  logic [can_txq_pkg::DropW-1:0] drop_q, drop_d;

  // ---------------------------------------------------------------------------
  // Output register: parts the input side from a stalled consumer
  // ---------------------------------------------------------------------------
  logic                           out_valid_q, out_valid_d;
  logic                           oload_q, oload_d;
  can_txq_pkg::entry_t            oentry_q, oentry_d;
  can_txq_pkg::outcome_e          outcome_q, outcome_d;
  logic [can_txq_pkg::FillW-1:0]  ofill_q, ofill_d;
  logic [can_txq_pkg::DropW-1:0]  odrop_q, odrop_d;
  logic                           load_out;

  // ring RAM port signals
  logic                ram_we, ram_re;
  can_txq_pkg::entry_t ram_wdata, ram_rdata;
  can_txq_pkg::entry_t in_entry;

  logic in_fire;

  assign in_entry.id       = msg_id_i;
  assign in_entry.extended = msg_extended_i;
  assign in_entry.length   = msg_length_i;
  assign in_entry.payload  = msg_payload_i;

  // Only one item is in flight at a time; a popping read blocks the input
  // until its data lands, so no write can hit the entry being read.
  assign in_ready_o = (state_q == can_txq_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(can_txq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  can_txq_ram #(
    .Width (can_txq_pkg::EntryW),
    .Depth (can_txq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = in_entry;

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    oload_d     = oload_q;
    oentry_d    = oentry_q;
    outcome_d   = outcome_q;
    ofill_d     = ofill_q;
    odrop_d     = odrop_q;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      can_txq_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (can_txq_pkg::opcode_e'(opcode_i))
            can_txq_pkg::OP_SUBMIT: begin
              load_out = 1'b1;
              if (cnt_q == '0 && !busy_q) begin
                // bypass: straight into the idle mailbox
                oload_d   = 1'b1;
                oentry_d  = in_entry;
                outcome_d = can_txq_pkg::OUT_DIRECT;
                busy_d    = 1'b1;
              end else if (cnt_q < CntW'(can_txq_pkg::QUEUE_DEPTH - 1)) begin
                ram_we    = 1'b1;
                wptr_d    = next_ptr(wptr_q);
                cnt_d     = cnt_q + 1'b1;
                oload_d   = 1'b0;
                oentry_d  = '0;
                outcome_d = can_txq_pkg::OUT_QUEUED;
              end else begin
                drop_d    = drop_q + 1'b1;
                oload_d   = 1'b0;
                oentry_d  = '0;
                outcome_d = can_txq_pkg::OUT_DROPPED;
              end
            end
            can_txq_pkg::OP_COMPLETE: begin
              if (cnt_q != '0) begin
                // pop oldest entry; result formed when read data returns
                ram_re  = 1'b1;
                rptr_d  = next_ptr(rptr_q);
                cnt_d   = cnt_q - 1'b1;
                busy_d  = 1'b1;
                state_d = can_txq_pkg::ST_READ;
              end else begin
                load_out  = 1'b1;
                busy_d    = 1'b0;
                oload_d   = 1'b0;
                oentry_d  = '0;
                outcome_d = can_txq_pkg::OUT_COMPLETE;
              end
            end
            default: begin
              state_d = can_txq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      can_txq_pkg::ST_READ: begin
        // output register is known empty here (input was taken only when free)
        load_out  = 1'b1;
        oload_d   = 1'b1;
        oentry_d  = ram_rdata;
        outcome_d = can_txq_pkg::OUT_COMPLETE;
        state_d   = can_txq_pkg::ST_IDLE;
      end
      default: begin
        state_d = can_txq_pkg::ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
      ofill_d     = can_txq_pkg::fill_sat(cnt_d);
      odrop_d     = drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= can_txq_pkg::ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oload_q   <= oload_d;
    oentry_q  <= oentry_d;
    outcome_q <= outcome_d;
    ofill_q   <= ofill_d;
    odrop_q   <= odrop_d;
  end

  assign out_valid_o    = out_valid_q;
  assign load_mailbox_o = oload_q;
  assign out_id_o       = oentry_q.id;
  assign out_extended_o = oentry_q.extended;
  assign out_length_o   = oentry_q.length;
  assign out_payload_o  = oentry_q.payload;
  assign outcome_o      = outcome_q;
  assign fill_level_o   = ofill_q;
  assign drop_total_o   = odrop_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // ring never holds more than depth-1 entries
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(can_txq_pkg::QUEUE_DEPTH - 1))
    else $error("ring count above capacity");

  // anything queued means the mailbox is occupied
  a_queued_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> busy_q)
    else $error("entries queued while mailbox idle");

  // a RAM read in flight always has a free output register to land in
  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == can_txq_pkg::ST_READ) |-> !out_valid_q)
    else $error("pop result would overwrite pending item");

  // drop counter only moves together with a dropped item
  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop_q != $past(drop_q)) |->
      (out_valid_q && outcome_q == can_txq_pkg::OUT_DROPPED && odrop_q == drop_q))
    else $error("drop counter changed without a dropped item");

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = can_txq_pkg::QUEUE_DEPTH;
  localparam int unsigned IdW         = can_txq_pkg::IdW;
  localparam int unsigned LenW        = can_txq_pkg::LenW;
  localparam int unsigned PayloadW    = can_txq_pkg::PayloadW;
  localparam int unsigned FillW       = can_txq_pkg::FillW;
  localparam int unsigned DropW       = can_txq_pkg::DropW;

  // Run limits. The cycle limit leaves a wide margin over the worst correct run.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned RAND_PHASES   = 28;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned QUIET_PHASES  = 4;   // last phases run with no idling at all

  // One result item as the mailbox side sees it.
  typedef struct packed {
    logic                  load;
    logic [IdW-1:0]        id;
    logic                  extended;
    logic [LenW-1:0]       length;
    logic [PayloadW-1:0]   payload;
    can_txq_pkg::outcome_e outcome;
    logic [FillW-1:0]      fill;
    logic [DropW-1:0]      drops;
  } mbox_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                opcode_i       = can_txq_pkg::OP_SUBMIT;
  logic [IdW-1:0]      msg_id_i       = '0;
  logic                msg_extended_i = 1'b0;
  logic [LenW-1:0]     msg_length_i   = '0;
  logic [PayloadW-1:0] msg_payload_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                load_mailbox_o;
  logic [IdW-1:0]      out_id_o;
  logic                out_extended_o;
  logic [LenW-1:0]     out_length_o;
  logic [PayloadW-1:0] out_payload_o;
  logic [1:0]          outcome_o;
  logic [FillW-1:0]    fill_level_o;
  logic [DropW-1:0]    drop_total_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  can_tx_queue_with_bypass_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .msg_id_i       (msg_id_i),
    .msg_extended_i (msg_extended_i),
    .msg_length_i   (msg_length_i),
    .msg_payload_i  (msg_payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .load_mailbox_o (load_mailbox_o),
    .out_id_o       (out_id_o),
    .out_extended_o (out_extended_o),
    .out_length_o   (out_length_o),
    .out_payload_o  (out_payload_o),
    .outcome_o      (outcome_o),
    .fill_level_o   (fill_level_o),
    .drop_total_o   (drop_total_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue: ring, pointers, count, mailbox flag, drop counter.
  // ---------------------------------------------------------------------------
  can_txq_pkg::entry_t shadow_ring [QUEUE_DEPTH];
  int unsigned         shadow_wr    = 0;
  int unsigned         shadow_rd    = 0;
  int unsigned         shadow_count = 0;
  bit                  shadow_busy  = 1'b0;
  logic [DropW-1:0]    shadow_drops = '0;

  mbox_result_t        pending_loads[$];   // expected results, oldest first
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  bit                  idle_en        = 1'b1;  // random gaps on both sides
  int unsigned         hold_cycles    = 0;     // long receiver hold-off request

  function automatic int unsigned ring_next(int unsigned ptr);
    return (ptr == QUEUE_DEPTH - 1) ? 0 : ptr + 1;
  endfunction

  // Apply one accepted item to the shadow queue and return what the mailbox side should see.
  function automatic mbox_result_t txq_predict(can_txq_pkg::opcode_e op,
                                               can_txq_pkg::entry_t msg);
    mbox_result_t res;
    res = '0;
    if (op == can_txq_pkg::OP_SUBMIT) begin
      if (shadow_count == 0 && !shadow_busy) begin
        // bypass: empty ring and idle mailbox
        res.load     = 1'b1;
        res.id       = msg.id;
        res.extended = msg.extended;
        res.length   = msg.length;
        res.payload  = msg.payload;
        res.outcome  = can_txq_pkg::OUT_DIRECT;
        shadow_busy  = 1'b1;
      end else if (shadow_count < QUEUE_DEPTH - 1) begin
        shadow_ring[shadow_wr] = msg;
        shadow_wr    = ring_next(shadow_wr);
        shadow_count = shadow_count + 1;
        res.outcome  = can_txq_pkg::OUT_QUEUED;
      end else begin
        // ring holds one entry fewer than its depth
        shadow_drops = shadow_drops + 1'b1;
        res.outcome  = can_txq_pkg::OUT_DROPPED;
      end
    end else begin
      if (shadow_count > 0) begin
        res.load     = 1'b1;
        res.id       = shadow_ring[shadow_rd].id;
        res.extended = shadow_ring[shadow_rd].extended;
        res.length   = shadow_ring[shadow_rd].length;
        res.payload  = shadow_ring[shadow_rd].payload;
        shadow_rd    = ring_next(shadow_rd);
        shadow_count = shadow_count - 1;
        shadow_busy  = 1'b1;
      end else begin
        shadow_busy  = 1'b0;
      end
      res.outcome = can_txq_pkg::OUT_COMPLETE;
    end
    res.fill  = (shadow_count > 15) ? 4'd15 : shadow_count[FillW-1:0];
    res.drops = shadow_drops;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called right after a rising edge; returns right after the edge that
  // accepted the item. Valid stays high into the next item unless a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_item(input can_txq_pkg::opcode_e op, input logic [IdW-1:0] id,
                           input logic ext, input logic [LenW-1:0] len,
                           input logic [PayloadW-1:0] payload);
    can_txq_pkg::entry_t msg;
    msg = '{id: id, extended: ext, length: len, payload: payload};
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    msg_id_i       <= id;
    msg_extended_i <= ext;
    msg_length_i   <= len;
    msg_payload_i  <= payload;
    do @(posedge clk_i); while (!in_ready_o);
    pending_loads.push_back(txq_predict(op, msg));
  endtask

  // Random message content; ids are either standard 11-bit or full 29-bit,
  // payloads now and then all zeros or all ones.
  task automatic send_random(input can_txq_pkg::opcode_e op);
    logic [IdW-1:0]      id;
    logic [PayloadW-1:0] payload;
    logic [LenW-1:0]     len;
    id = ($urandom_range(0, 2) == 0) ? IdW'($urandom_range(0, 11'h7FF)) : IdW'($urandom);
    case ($urandom_range(0, 9))
      0:       payload = '0;
      1:       payload = '1;
      default: payload = {$urandom, $urandom};
    endcase
    // mostly legal lengths, but lengths above eight also pass through
    len = ($urandom_range(0, 3) == 0) ? LenW'($urandom_range(9, 15)) : LenW'($urandom_range(0, 8));
    send_item(op, id, 1'($urandom), len, payload);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off,
  // which it counts down itself.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left = stall_left - 1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mbox_result_t got;
    mbox_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{load: load_mailbox_o, id: out_id_o, extended: out_extended_o,
              length: out_length_o, payload: out_payload_o,
              outcome: can_txq_pkg::outcome_e'(outcome_o),
              fill: fill_level_o, drops: drop_total_o};
      if (pending_loads.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result load=%0d id=%h outcome=%0d", $realtime,
                   got.load, got.id, got.outcome);
      end else begin
        want = pending_loads.pop_front();
        if (got.load !== want.load || got.id !== want.id || got.extended !== want.extended ||
            got.length !== want.length || got.payload !== want.payload ||
            got.outcome !== want.outcome || got.fill !== want.fill ||
            got.drops !== want.drops) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: exp load=%0d id=%h ext=%0d len=%0d pl=%h oc=%0d fill=%0d drops=%0d",
                     $realtime, want.load, want.id, want.extended, want.length, want.payload,
                     want.outcome, want.fill, want.drops);
            $display("%0t: got load=%0d id=%h ext=%0d len=%0d pl=%h oc=%0d fill=%0d drops=%0d",
                     $realtime, got.load, got.id, got.extended, got.length, got.payload,
                     got.outcome, got.fill, got.drops);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Completion on an idle, empty queue; field extremes through bypass and ring;
  // popping in order; completion that returns the mailbox to idle.
  task automatic test_directed_corners();
    send_item(can_txq_pkg::OP_COMPLETE, '1, 1'b1, '1, '1);   // idle, nothing queued
    send_item(can_txq_pkg::OP_SUBMIT, '1, 1'b1, 4'd15, '1);  // bypass, length above eight
    send_item(can_txq_pkg::OP_SUBMIT, '0, 1'b0, 4'd0, '0);   // queued, all zero
    send_item(can_txq_pkg::OP_SUBMIT, 29'h155, 1'b0, 4'd8, 64'hA5A5_5A5A_0F0F_F0F0);
    send_item(can_txq_pkg::OP_COMPLETE, '0, 1'b0, '0, '0);   // pops oldest
    send_item(can_txq_pkg::OP_COMPLETE, '0, 1'b0, '0, '0);   // pops last entry
    send_item(can_txq_pkg::OP_COMPLETE, '0, 1'b0, '0, '0);   // ring empty, mailbox idle
    send_item(can_txq_pkg::OP_COMPLETE, '0, 1'b0, '0, '0);   // still idle
  endtask

  // Bypass, then fill the ring past the pointer wrap, then one drop.
  task automatic test_fill_and_drop();
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_item(can_txq_pkg::OP_SUBMIT, IdW'(29'h1000_0000 | i), i[0], LenW'(i % 9),
                {32'hDEAD_0000 | i, 32'hFFFF_FFFF - i});
  endtask

  // Receiver stops for a long stretch while items keep coming, so the output
  // side backs up and the input stalls.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_cycles = 60;
    for (int i = 0; i < 24; i++)
      send_random((i % 4 == 3) ? can_txq_pkg::OP_COMPLETE : can_txq_pkg::OP_SUBMIT);
    idle_en = 1'b1;
  endtask

  // Phases of random traffic with differing submit/complete mix, so the ring
  // swings between empty, partly full and full with drops.
  task automatic test_random_traffic();
    int unsigned submit_pct;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       submit_pct = 25;
        1:       submit_pct = 50;
        2:       submit_pct = 70;
        default: submit_pct = 90;
      endcase
      // some phases without idling in the middle, none in the last part
      idle_en = (p < RAND_PHASES - QUIET_PHASES) && ($urandom_range(0, 4) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random(($urandom_range(1, 100) <= submit_pct) ? can_txq_pkg::OP_SUBMIT
                                                           : can_txq_pkg::OP_COMPLETE);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_fill_and_drop();
    test_backpressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_loads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
design/can_txq_pkg.sv
design/can_txq_ram.sv
design/can_tx_queue_with_bypass_core.sv
sim/tb_top.sv
